>>> rtl/core/kam_pkg.sv
// ----------------------------------------------------------------------------
// kam_pkg: keyword action matcher shared definitions
// request and result types, phase codes and character constants
// ----------------------------------------------------------------------------
`default_nettype none

package kam_pkg;

    localparam int ENTRIES    = 16;
    localparam int TOKEN_MAX  = 16;
    localparam int ENTRY_W    = 4;
    localparam int CHAR_POS_W = 4;
    localparam int LEN_W      = 5;
    localparam int COUNT_W    = 5;
    localparam int POS_W      = 5;
    localparam int BYTE_W     = 8;
    localparam int PARAM_W    = 5;

    localparam logic [POS_W-1:0] POS_MAX = 5'd31;

    localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CHAR_G     = 8'h47;
    localparam logic [BYTE_W-1:0] CHAR_S     = 8'h53;
    localparam logic [BYTE_W-1:0] CHAR_U     = 8'h55;
    localparam logic [BYTE_W-1:0] CHAR_D     = 8'h44;

    typedef enum logic [1:0] {
        REQ_CHAR = 2'd0,
        REQ_LEN  = 2'd1,
        REQ_CMD  = 2'd2,
        REQ_NONE = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        PH_TOKEN        = 3'd0,
        PH_AFTER_TOKEN  = 3'd1,
        PH_AFTER_COLON  = 3'd2,
        PH_AFTER_ACTION = 3'd3,
        PH_DONE         = 3'd4,
        PH_BAD          = 3'd5,
        PH_DEAD         = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_NONE       = 2'd0,
        ST_MATCH      = 2'd1,
        ST_BAD_ACTION = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ACT_GET    = 2'd0,
        ACT_SET    = 2'd1,
        ACT_UPDATE = 2'd2,
        ACT_DELETE = 2'd3
    } action_t;

    // one request travelling down the chain, with the partial result
    typedef struct packed {
        req_type_t              req_type;
        logic [ENTRY_W-1:0]     entry_index;
        logic [CHAR_POS_W-1:0]  char_pos;
        logic [BYTE_W-1:0]      char_value;
        logic [LEN_W-1:0]       token_length;
        logic                   cmd_last;
        logic [POS_W-1:0]       byte_pos;
        status_t                match_status;
        logic [ENTRY_W-1:0]     matched_entry;
        action_t                action_code;
        logic [PARAM_W-1:0]     param_start;
    } kam_req_t;

    function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
        return (p == POS_MAX) ? p : p + 5'd1;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/kam_cell.sv
// ----------------------------------------------------------------------------
// kam_cell: one keyword entry of the matcher chain
// holds one token and its match progress, passes each request to the next cell
// ----------------------------------------------------------------------------
`default_nettype none

module kam_cell import kam_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire logic [ENTRY_W-1:0]   cell_id,
    input  wire logic [COUNT_W-1:0]   entry_count,
    input  wire logic                 up_valid,
    input  wire kam_req_t             up_req,
    output logic                      dn_valid,
    output kam_req_t                  dn_req
);

    logic [BYTE_W-1:0] text_reg [TOKEN_MAX];
    logic [LEN_W-1:0]  len_reg, len_next;
    phase_t            phase_reg, phase_next;
    action_t           act_reg, act_next;
    logic [PARAM_W-1:0] off_reg, off_next;
    logic              dn_valid_reg;
    kam_req_t          dn_req_reg, dn_req_next;

    phase_t            adv_phase, eff_phase;
    action_t           adv_act, letter_act;
    logic [PARAM_W-1:0] adv_off;
    logic              letter_ok, in_token, fire, is_cmd, is_mine;
    logic [POS_W-1:0]  p, np;
    logic [BYTE_W-1:0] b, tok_char;

    assign fire     = advance && up_valid;
    assign is_cmd   = (up_req.req_type == REQ_CMD);
    assign is_mine  = (up_req.entry_index == cell_id);
    assign b        = up_req.char_value;
    assign p        = up_req.byte_pos;
    assign np       = next_pos(p);
    assign tok_char = text_reg[p[CHAR_POS_W-1:0]];
    assign in_token = (phase_reg == PH_TOKEN) && (p < len_reg);
    assign eff_phase = (phase_reg == PH_TOKEN) ? PH_AFTER_TOKEN : phase_reg;

    // action letter decode
    always_comb
    begin
        letter_ok  = 1'b1;
        letter_act = ACT_GET;
        unique case (b)
            CHAR_G:  letter_act = ACT_GET;
            CHAR_S:  letter_act = ACT_SET;
            CHAR_U:  letter_act = ACT_UPDATE;
            CHAR_D:  letter_act = ACT_DELETE;
            default: letter_ok  = 1'b0;
        endcase
    end

    // progress of this entry after the current command byte
    always_comb
    begin
        adv_phase = phase_reg;
        adv_act   = act_reg;
        adv_off   = off_reg;
        if (in_token)
        begin
            if (tok_char != b)
            begin
                adv_phase = PH_DEAD;
                adv_act   = ACT_GET;
            end
        end
        else
        begin
            case (eff_phase) inside
                PH_AFTER_TOKEN, PH_AFTER_COLON:
                begin
                    if (eff_phase == PH_AFTER_TOKEN && b == CHAR_COLON)
                    begin
                        adv_phase = PH_AFTER_COLON;
                        adv_act   = ACT_GET;
                        adv_off   = np;
                    end
                    else if (letter_ok)
                    begin
                        adv_phase = PH_AFTER_ACTION;
                        adv_act   = letter_act;
                        adv_off   = np;
                    end
                    else
                    begin
                        adv_phase = PH_BAD;
                        adv_act   = ACT_GET;
                    end
                end
                PH_AFTER_ACTION:
                begin
                    if (b == CHAR_COLON)
                    begin
                        adv_off = np;
                    end
                    adv_phase = PH_DONE;
                end
                default: ;
            endcase
        end
    end

    // state next values
    always_comb
    begin
        phase_next = phase_reg;
        act_next   = act_reg;
        off_next   = off_reg;
        len_next   = len_reg;
        if (fire && up_req.req_type == REQ_LEN && is_mine)
        begin
            len_next = (up_req.token_length > LEN_W'(TOKEN_MAX)) ?
                       LEN_W'(TOKEN_MAX) : up_req.token_length;
        end
        if (fire && is_cmd)
        begin
            if (up_req.cmd_last)
            begin
                phase_next = PH_TOKEN;
                act_next   = ACT_GET;
                off_next   = '0;
            end
            else
            begin
                phase_next = adv_phase;
                act_next   = adv_act;
                off_next   = adv_off;
            end
        end
    end

    // first-match resolution on the last command byte
    always_comb
    begin
        dn_req_next = up_req;
        if (is_cmd && up_req.cmd_last && up_req.match_status == ST_NONE &&
            {1'b0, cell_id} < entry_count)
        begin
            case (adv_phase)
                PH_DEAD: ;
                PH_BAD:
                begin
                    dn_req_next.match_status  = ST_BAD_ACTION;
                    dn_req_next.matched_entry = cell_id;
                end
                PH_TOKEN:
                begin
                    if (np == len_reg)
                    begin
                        dn_req_next.match_status  = ST_MATCH;
                        dn_req_next.matched_entry = cell_id;
                        dn_req_next.action_code   = ACT_GET;
                        dn_req_next.param_start   = np;
                    end
                end
                PH_AFTER_COLON:
                begin
                    dn_req_next.match_status  = ST_MATCH;
                    dn_req_next.matched_entry = cell_id;
                    dn_req_next.action_code   = ACT_GET;
                    dn_req_next.param_start   = np;
                end
                default:
                begin
                    dn_req_next.match_status  = ST_MATCH;
                    dn_req_next.matched_entry = cell_id;
                    dn_req_next.action_code   = adv_act;
                    dn_req_next.param_start   = adv_off;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_TOKEN;
            act_reg      <= ACT_GET;
            off_reg      <= '0;
            len_reg      <= '0;
            dn_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            act_reg   <= act_next;
            off_reg   <= off_next;
            len_reg   <= len_next;
            if (advance)
            begin
                dn_valid_reg <= up_valid;
            end
        end
    end

    // token text and stage payload, no reset
    always_ff @(posedge clk)
    begin
        if (fire && up_req.req_type == REQ_CHAR && is_mine)
        begin
            text_reg[up_req.char_pos] <= b;
        end
        if (advance)
        begin
            dn_req_reg <= dn_req_next;
        end
    end

    assign dn_valid = dn_valid_reg;
    assign dn_req   = dn_req_reg;

endmodule

`default_nettype wire

>>> rtl/core/command_keyword_action_matcher.sv
// ----------------------------------------------------------------------------
// command_keyword_action_matcher: keyword table and command matcher
// systolic row of keyword cells with a shared result register at the end
// ----------------------------------------------------------------------------
// Every request (token character write, token length write or command byte)
// enters a row of 16 cells, one per table entry, and moves one cell per
// cycle. Each cell holds its token and tracks its own match progress, so
// table writes and command bytes stay in order for every entry. One request
// is taken per clock; the last byte of a command passes the cell registers
// and then the result register, and it collects the first matching entry
// as it passes the cells in index order. The whole row stalls only while
// a result waits in the output register and out_ready is low. The user
// must write entry_count only while the block is idle; the block itself
// does not enforce it.
`default_nettype none

module command_keyword_action_matcher import kam_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  cfg_wr_en,
    input  wire logic [COUNT_W-1:0]    cfg_wr_data,
    // request channel
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            req_type,
    input  wire logic [ENTRY_W-1:0]    entry_index,
    input  wire logic [CHAR_POS_W-1:0] char_pos,
    input  wire logic [BYTE_W-1:0]     char_value,
    input  wire logic [LEN_W-1:0]      token_length,
    input  wire logic                  cmd_last,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 match_status,
    output logic [ENTRY_W-1:0]         matched_entry,
    output logic [1:0]                 action_code,
    output logic [PARAM_W-1:0]         param_start
);

    logic [COUNT_W-1:0] entry_count_reg;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               out_valid_reg, out_valid_next;
    kam_req_t           out_req_reg;
    logic               advance, in_fire, tail_result;
    kam_req_t           head_req;

    logic               chain_valid [ENTRIES+1];
    kam_req_t           chain_req   [ENTRIES+1];

    // the row moves unless a result is stuck in the output register
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;
    assign in_fire  = in_valid && advance;

    // byte position of the next command byte, saturating, cleared at command end
    always_comb
    begin
        pos_next = pos_reg;
        if (in_fire && req_type_t'(req_type) == REQ_CMD)
        begin
            pos_next = cmd_last ? '0 : next_pos(pos_reg);
        end
    end

    // request as it enters the first cell, with an empty partial result
    always_comb
    begin
        head_req.req_type      = req_type_t'(req_type);
        head_req.entry_index   = entry_index;
        head_req.char_pos      = char_pos;
        head_req.char_value    = char_value;
        head_req.token_length  = token_length;
        head_req.cmd_last      = cmd_last;
        head_req.byte_pos      = pos_reg;
        head_req.match_status  = ST_NONE;
        head_req.matched_entry = '0;
        head_req.action_code   = ACT_GET;
        head_req.param_start   = '0;
    end

    assign chain_valid[0] = in_valid;
    assign chain_req[0]   = head_req;

    // one cell per table entry
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        kam_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .advance     (advance),
            .cell_id     (ENTRY_W'(i)),
            .entry_count (entry_count_reg),
            .up_valid    (chain_valid[i]),
            .up_req      (chain_req[i]),
            .dn_valid    (chain_valid[i+1]),
            .dn_req      (chain_req[i+1])
        );
    end

    // only the last byte of a command produces a result
    assign tail_result = chain_valid[ENTRIES] &&
                         chain_req[ENTRIES].req_type == REQ_CMD &&
                         chain_req[ENTRIES].cmd_last;

    assign out_valid_next = advance ? tail_result : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            pos_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                entry_count_reg <= cfg_wr_data;
            end
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance && tail_result)
        begin
            out_req_reg <= chain_req[ENTRIES];
        end
    end

    assign out_valid     = out_valid_reg;
    assign match_status  = out_req_reg.match_status;
    assign matched_entry = out_req_reg.matched_entry;
    assign action_code   = out_req_reg.action_code;
    assign param_start   = out_req_reg.param_start;

endmodule

`default_nettype wire

>>> rtl/core/kam_checker.sv
// ----------------------------------------------------------------------------
// kam_checker: port-level checks for the keyword action matcher
// watches the result channel and the request back-pressure
// ----------------------------------------------------------------------------
`default_nettype none

module kam_checker import kam_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_ready,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [1:0]            match_status,
    input  wire logic [ENTRY_W-1:0]    matched_entry,
    input  wire logic [1:0]            action_code,
    input  wire logic [PARAM_W-1:0]    param_start
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(match_status) &&
        $stable(matched_entry) && $stable(action_code) && $stable(param_start))
        else $error("result changed while stalled");

    // no match reports all-zero fields
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && match_status == ST_NONE |->
        matched_entry == '0 && action_code == ACT_GET && param_start == '0)
        else $error("no-match result with nonzero fields");

    // bad action reports no action and no parameter offset
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && match_status == ST_BAD_ACTION |->
        action_code == ACT_GET && param_start == '0)
        else $error("bad-action result with action or offset");

    // status code stays within the defined set
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> match_status == ST_NONE || match_status == ST_MATCH ||
        match_status == ST_BAD_ACTION)
        else $error("undefined match status");

    // requests are held back only by a waiting result
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("request stalled with no waiting result");

endmodule

bind command_keyword_action_matcher kam_checker u_kam_checker (.*);

`default_nettype wire
